/* hdl/ncca_pkg.sv */
// Package for the nearest core cluster assignment block.
// Holds sizes, command and register codes and the cell interface type; no dependencies.
package ncca_pkg;

	localparam int MaxClusters = 16;
	localparam int MaxCoresPerCluster = 4;
	localparam int MaxPoints = 1024;
	localparam int NumSlots = MaxClusters * MaxCoresPerCluster;
	localparam int SlotW = $clog2(NumSlots);
	localparam int PointW = $clog2(MaxPoints);
	localparam int LabelW = 4;
	localparam int CoordW = 16;
	localparam int DistW = 33;

	localparam logic [1:0] CmdLoad = 2'd0;
	localparam logic [1:0] CmdClassify = 2'd1;
	localparam logic [1:0] CmdClear = 2'd2;
	localparam logic [1:0] CmdSpare = 2'd3;

	localparam logic [1:0] RegNumClusters = 2'd0;
	localparam logic [1:0] RegCoresPerCluster = 2'd1;
	localparam logic [1:0] RegInitialPass = 2'd2;
	localparam logic [1:0] RegSpare = 2'd3;

	// Token that walks down the chain of cells.
	typedef struct packed {
		logic valid;
		logic signed [CoordW-1:0] px;
		logic signed [CoordW-1:0] py;
		logic [SlotW:0] nslots;
		logic [DistW-1:0] best;
		logic [SlotW-1:0] best_slot;
	} tok_t;

endpackage

/* hdl/ncca_cell.sv */
// One cell of the distance chain: holds one core point, compares the token.
// Depends on ncca_pkg.
module ncca_cell (
	input  logic clk,
	input  logic arst_n,
	input  logic [ncca_pkg::SlotW-1:0] slot,
	input  logic load,
	input  logic signed [ncca_pkg::CoordW-1:0] load_x,
	input  logic signed [ncca_pkg::CoordW-1:0] load_y,
	input  ncca_pkg::tok_t tok_in,
	output ncca_pkg::tok_t tok_out
);
	logic signed [ncca_pkg::CoordW-1:0] cx_q, cy_q;
	logic signed [ncca_pkg::CoordW:0] dx, dy;
	logic [ncca_pkg::CoordW:0] ax, ay;
	logic [2*ncca_pkg::CoordW+1:0] sx, sy;
	logic [ncca_pkg::DistW-1:0] d;
	logic use_it, take;

	always_ff @(posedge clk) begin
		if (load) begin
			cx_q <= load_x;
			cy_q <= load_y;
		end
	end

	always_comb begin
		dx = {tok_in.px[ncca_pkg::CoordW-1], tok_in.px} - {cx_q[ncca_pkg::CoordW-1], cx_q};
		dy = {tok_in.py[ncca_pkg::CoordW-1], tok_in.py} - {cy_q[ncca_pkg::CoordW-1], cy_q};
		ax = dx[ncca_pkg::CoordW] ? (ncca_pkg::CoordW+1)'(0) - dx : dx;
		ay = dy[ncca_pkg::CoordW] ? (ncca_pkg::CoordW+1)'(0) - dy : dy;
		sx = ax * ax;
		sy = ay * ay;
		d = ncca_pkg::DistW'(sx) + ncca_pkg::DistW'(sy);
		use_it = {1'b0, slot} < tok_in.nslots;
		take = use_it && (slot == '0 || d < tok_in.best);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_out <= '0;
		end else begin
			tok_out.valid <= tok_in.valid;
			tok_out.px <= tok_in.px;
			tok_out.py <= tok_in.py;
			tok_out.nslots <= tok_in.nslots;
			tok_out.best <= take ? d : tok_in.best;
			tok_out.best_slot <= take ? slot : tok_in.best_slot;
		end
	end
endmodule

/* hdl/ncca_ram.sv */
// Generic single-port RAM with registered read.
// No dependencies.
module ncca_ram #(
	parameter int Width = 4,
	parameter int Depth = 1024
) (
	input  logic clk,
	input  logic we,
	input  logic [$clog2(Depth)-1:0] addr,
	input  logic [Width-1:0] wdata,
	output logic [Width-1:0] rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

/* hdl/nearest_core_cluster_assign.sv */
// Top level of the block; depends on ncca_pkg, ncca_cell and ncca_ram.
// A classify request walks the 64-cell distance chain, then reads the old label in StRead
// and registers its result for StOut; load, clear and unused commands go straight to
// StOut. One request is in flight at a time: s_axis_tready is high only in StIdle, so a new
// one waits until the last result is taken. Reset restores the register defaults and
// clears the pass flag; the core table and point labels hold nothing until written.
module nearest_core_cluster_assign (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	input  logic [47:0] s_axis_tdata, // index[9:0], x_coord[25:10], y_coord[41:26]
	input  logic [1:0] s_axis_tuser,  // command
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	output logic [39:0] m_axis_tdata, // label, changed, pass_changed, min_distance
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [4:0] cfg_data
);
	typedef enum logic [3:0] {
		StIdle = 4'b0001, StChain = 4'b0010, StRead = 4'b0100, StOut = 4'b1000
	} state_t;

	state_t state_q;
	logic [4:0] ncl_q;
	logic [2:0] cpc_q;
	logic ini_q, pass_q;
	logic [ncca_pkg::PointW-1:0] idx_q;
	ncca_pkg::tok_t tok_head;
	ncca_pkg::tok_t chain [ncca_pkg::NumSlots+1];
	ncca_pkg::tok_t res_q;
	logic [ncca_pkg::LabelW-1:0] lbl_q, old_lbl;
	logic [39:0] out_q;
	logic [4:0] k;
	logic [2:0] p;
	logic [ncca_pkg::SlotW-1:0] lbl_full;
	logic accept, lab_we;
	logic [ncca_pkg::SlotW:0] nsl;
	logic chg;

	assign cfg_ready = 1'b1;
	assign s_axis_tready = (state_q == StIdle);
	assign accept = s_axis_tvalid && s_axis_tready;
	assign m_axis_tvalid = (state_q == StOut);
	assign m_axis_tdata = out_q;

	always_comb begin
		k = (ncl_q == 5'd0) ? 5'd1 : (ncl_q > 5'(ncca_pkg::MaxClusters)) ?
			5'(ncca_pkg::MaxClusters) : ncl_q;
		p = (cpc_q == 3'd0) ? 3'd1 : (cpc_q > 3'(ncca_pkg::MaxCoresPerCluster)) ?
			3'(ncca_pkg::MaxCoresPerCluster) : cpc_q;
		nsl = ini_q ? (ncca_pkg::SlotW+1)'(k) :
			(ncca_pkg::SlotW+1)'(k) * (ncca_pkg::SlotW+1)'(p);
		tok_head.valid = accept && s_axis_tuser == ncca_pkg::CmdClassify;
		tok_head.px = s_axis_tdata[25:10];
		tok_head.py = s_axis_tdata[41:26];
		tok_head.nslots = nsl;
		tok_head.best = '0;
		tok_head.best_slot = '0;
	end

	assign chain[0] = tok_head;

	for (genvar i = 0; i < ncca_pkg::NumSlots; i++) begin : g_cell
		ncca_cell u_cell (
			.clk(clk), .arst_n(arst_n), .slot(ncca_pkg::SlotW'(i)),
			.load(accept && s_axis_tuser == ncca_pkg::CmdLoad
				&& s_axis_tdata[9:0] == 10'(i)),
			.load_x(s_axis_tdata[25:10]), .load_y(s_axis_tdata[41:26]),
			.tok_in(chain[i]), .tok_out(chain[i+1])
		);
	end

	// Divide by cores per cluster by shift or multiply; skipped in the initial pass.
	always_comb begin
		lbl_full = chain[ncca_pkg::NumSlots].best_slot;
		case (p)
			3'd2: lbl_full = chain[ncca_pkg::NumSlots].best_slot >> 1;
			3'd3: lbl_full = ncca_pkg::SlotW'((16'(chain[ncca_pkg::NumSlots].best_slot)
				* 16'd683) >> 11);
			3'd4: lbl_full = chain[ncca_pkg::NumSlots].best_slot >> 2;
			default: lbl_full = chain[ncca_pkg::NumSlots].best_slot;
		endcase
		if (ini_q) lbl_full = chain[ncca_pkg::NumSlots].best_slot;
	end

	assign lab_we = (state_q == StRead);
	ncca_ram #(.Width(ncca_pkg::LabelW), .Depth(ncca_pkg::MaxPoints)) u_labels (
		.clk(clk), .we(lab_we), .addr(idx_q), .wdata(lbl_q), .rdata(old_lbl)
	);

	assign chg = !ini_q && (old_lbl != lbl_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= StIdle;
			ncl_q <= 5'd2;
			cpc_q <= 3'd1;
			ini_q <= 1'b1;
			pass_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					ncca_pkg::RegNumClusters: ncl_q <= cfg_data;
					ncca_pkg::RegCoresPerCluster: cpc_q <= cfg_data[2:0];
					ncca_pkg::RegInitialPass: ini_q <= cfg_data[0];
					default: ;
				endcase
			end
			case (state_q)
				StIdle: begin
					if (accept) begin
						if (s_axis_tuser == ncca_pkg::CmdClassify) begin
							state_q <= StChain;
						end else begin
							state_q <= StOut;
							if (s_axis_tuser == ncca_pkg::CmdClear) pass_q <= 1'b0;
						end
					end
				end
				StChain: begin
					if (chain[ncca_pkg::NumSlots].valid) state_q <= StRead;
				end
				StRead: begin
					state_q <= StOut;
					pass_q <= pass_q | chg;
				end
				StOut: if (m_axis_tready) state_q <= StIdle;
				default: state_q <= StIdle;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			idx_q <= s_axis_tdata[ncca_pkg::PointW-1:0];
			out_q <= '0;
		end
		if (state_q == StChain && chain[ncca_pkg::NumSlots].valid) begin
			res_q <= chain[ncca_pkg::NumSlots];
			lbl_q <= lbl_full[ncca_pkg::LabelW-1:0];
		end
		if (state_q == StRead) begin
			out_q <= {1'b0, res_q.best, pass_q | chg, chg, lbl_q};
		end
	end
endmodule

/* test/tb_top.sv */
// Self-checking testbench for nearest_core_cluster_assign, drives streamed requests,
// mirrors the core table and point labels, and checks every result field by field.
// Depends on ncca_pkg and the block's RTL only.
module tb_top;

	typedef struct packed {
		logic [ncca_pkg::DistW-1:0] min_dist;
		logic pass_changed;
		logic changed;
		logic [ncca_pkg::LabelW-1:0] label;
	} result_t;

	typedef struct {
		logic [1:0] cmd;
		logic [9:0] idx;
		logic [15:0] x;
		logic [15:0] y;
		bit typed;
		result_t res;
	} row_t;

	logic clk;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [47:0] s_axis_tdata;
	logic [1:0] s_axis_tuser;
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [39:0] m_axis_tdata;
	logic cfg_valid;
	logic cfg_ready;
	logic [1:0] cfg_index;
	logic [4:0] cfg_data;

	nearest_core_cluster_assign i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		clk = 0;
		#1;
		clk = 1;
		#1;
	end

	// Mirror of the block state.
	logic signed [ncca_pkg::CoordW-1:0] core_x [ncca_pkg::NumSlots];
	logic signed [ncca_pkg::CoordW-1:0] core_y [ncca_pkg::NumSlots];
	logic [ncca_pkg::LabelW-1:0] point_label [ncca_pkg::MaxPoints];
	logic pass_flag;
	logic [4:0] reg_clusters;
	logic [2:0] reg_cores;
	logic reg_initial;

	result_t labels_due [$];
	int errors;
	int n_results;
	int n_classify;
	int n_changed;
	int n_ties;
	bit cur_typed;
	result_t cur_res;
	bit idle_on;
	bit hold_req;
	bit stim_initial;
	bit pt_written [ncca_pkg::MaxPoints];
	int pt_list [$];

	function automatic result_t apply_request(logic [1:0] cmd, logic [9:0] idx,
			logic signed [15:0] x, logic signed [15:0] y);
		int k;
		int p;
		int n;
		int bs;
		longint dx;
		longint dy;
		longint d;
		longint best;
		result_t r;
		r = '0;
		case (cmd)
			ncca_pkg::CmdLoad: begin
				if (idx < ncca_pkg::NumSlots) begin
					core_x[idx] = x;
					core_y[idx] = y;
				end
			end
			ncca_pkg::CmdClear: pass_flag = 0;
			ncca_pkg::CmdClassify: begin
				k = reg_clusters < 1 ? 1 : (reg_clusters > ncca_pkg::MaxClusters ?
					ncca_pkg::MaxClusters : reg_clusters);
				p = reg_cores < 1 ? 1 : (reg_cores > ncca_pkg::MaxCoresPerCluster ?
					ncca_pkg::MaxCoresPerCluster : reg_cores);
				n = reg_initial ? k : k * p;
				best = 0;
				bs = 0;
				for (int s = 0; s < n; s++) begin
					dx = longint'(x) - longint'(core_x[s]);
					dy = longint'(y) - longint'(core_y[s]);
					d = dx * dx + dy * dy;
					if (s != 0 && d == best)
						n_ties++;
					if (s == 0 || d < best) begin
						best = d;
						bs = s;
					end
				end
				r.label = reg_initial ? ncca_pkg::LabelW'(bs) : ncca_pkg::LabelW'(bs / p);
				r.changed = !reg_initial && point_label[idx] != r.label;
				point_label[idx] = r.label;
				pass_flag = pass_flag | r.changed;
				r.pass_changed = pass_flag;
				r.min_dist = best[ncca_pkg::DistW-1:0];
			end
			default: ;
		endcase
		return r;
	endfunction

	task automatic report(string what, result_t got, result_t want);
		$display("MISMATCH %s: got label=%0d chg=%0d pc=%0d dist=%0d, want %0d %0d %0d %0d",
			what, got.label, got.changed, got.pass_changed, got.min_dist,
			want.label, want.changed, want.pass_changed, want.min_dist);
		errors++;
	endtask

	always @(posedge clk) begin
		result_t r;
		result_t got;
		result_t want;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					ncca_pkg::RegNumClusters: reg_clusters = cfg_data;
					ncca_pkg::RegCoresPerCluster: reg_cores = cfg_data[2:0];
					ncca_pkg::RegInitialPass: reg_initial = cfg_data[0];
					default: ;
				endcase
			end
			if (s_axis_tvalid && s_axis_tready) begin
				r = apply_request(s_axis_tuser, s_axis_tdata[9:0], s_axis_tdata[25:10],
					s_axis_tdata[41:26]);
				if (s_axis_tuser == ncca_pkg::CmdClassify)
					n_classify++;
				labels_due.push_back(cur_typed ? cur_res : r);
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got = m_axis_tdata[38:0];
				n_results++;
				if (got.changed)
					n_changed++;
				if (labels_due.size() == 0) begin
					report("unexpected result", got, '0);
				end else begin
					want = labels_due.pop_front();
					if (got.label != want.label)
						report("label", got, want);
					else if (got.changed != want.changed)
						report("changed", got, want);
					else if (got.pass_changed != want.pass_changed)
						report("pass_changed", got, want);
					else if (got.min_dist != want.min_dist)
						report("min_distance", got, want);
				end
			end
		end
	end

	int quiet_cycles;
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= 3000) begin
			$display("Watchdog expired with %0d results outstanding.", labels_due.size());
			$display("Test completed with failures");
			$finish;
		end
	end

	// Result side: random stall bursts and one long hold-off.
	initial begin
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 0;
				m_axis_tready <= 0;
				repeat (300) @(negedge clk);
			end else if (idle_on && $urandom_range(0, 7) == 0) begin
				m_axis_tready <= 0;
				repeat ($urandom_range(1, 10)) @(negedge clk);
			end
			m_axis_tready <= 1;
		end
	end

	task automatic send(logic [1:0] cmd, logic [9:0] idx, logic [15:0] x, logic [15:0] y,
			bit typed, result_t res);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 0;
			repeat ($urandom_range(1, 10)) @(negedge clk);
		end
		s_axis_tvalid <= 1;
		s_axis_tuser <= cmd;
		s_axis_tdata <= {6'b0, y, x, idx};
		cur_typed <= typed;
		cur_res <= res;
		do
			@(posedge clk);
		while (!s_axis_tready);
		@(negedge clk);
	endtask

	task automatic drain();
		s_axis_tvalid <= 0;
		while (labels_due.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [4:0] data);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= data;
		do
			@(posedge clk);
		while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 0;
	endtask

	function automatic logic [15:0] rand_coord();
		case ($urandom_range(0, 3))
			0: return $urandom_range(0, 3) == 0 ? 16'h8000 :
				($urandom_range(0, 1) ? 16'h7fff : 16'hffff);
			1: return 16'($signed($urandom_range(0, 6)) - 3);
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic send_random();
		int pick;
		logic [9:0] idx;
		pick = $urandom_range(0, 99);
		if (pick < 10) begin
			send(ncca_pkg::CmdLoad,
				$urandom_range(0, 7) == 0 ? 10'($urandom) : 10'($urandom_range(0, 63)),
				rand_coord(), rand_coord(), 0, '0);
		end else if (pick < 14) begin
			send(ncca_pkg::CmdClear, 10'($urandom), 16'($urandom), 16'($urandom), 0, '0);
		end else if (pick < 16) begin
			send(ncca_pkg::CmdSpare, 10'($urandom), 16'($urandom), 16'($urandom), 0, '0);
		end else begin
			if (stim_initial || pt_list.size() == 0) begin
				idx = 10'($urandom);
				if (!stim_initial)
					return;
				if (!pt_written[idx]) begin
					pt_written[idx] = 1;
					pt_list.push_back(idx);
				end
			end else begin
				idx = 10'(pt_list[$urandom_range(0, pt_list.size() - 1)]);
			end
			send(ncca_pkg::CmdClassify, idx, rand_coord(), rand_coord(), 0, '0);
		end
	endtask

	task automatic set_config(int k, int p, int init);
		drain();
		write_reg(ncca_pkg::RegNumClusters, 5'(k));
		write_reg(ncca_pkg::RegCoresPerCluster, 5'(p));
		write_reg(ncca_pkg::RegInitialPass, 5'(init));
		stim_initial = (init != 0);
	endtask

	row_t rows [$];
	int phase_k [10] = '{16, 16, 1, 0, 31, 5, 7, 12, 3, 9};
	int phase_p [10] = '{4, 4, 1, 0, 7, 3, 2, 4, 4, 2};
	int phase_i [10] = '{1, 0, 0, 0, 0, 0, 1, 0, 0, 0};
	int phase_n [10] = '{150, 160, 100, 60, 100, 150, 100, 200, 200, 150};

	initial begin
		arst_n = 0;
		s_axis_tvalid = 0;
		s_axis_tdata = '0;
		s_axis_tuser = ncca_pkg::CmdLoad;
		m_axis_tready = 0;
		cfg_valid = 0;
		cfg_index = ncca_pkg::RegNumClusters;
		cfg_data = '0;
		cur_typed = 0;
		cur_res = '0;
		idle_on = 1;
		hold_req = 0;
		stim_initial = 1;
		errors = 0;
		pass_flag = 0;
		reg_clusters = 2;
		reg_cores = 1;
		reg_initial = 1;
		// After reset: two clusters, one core each, initial pass.
		rows = '{
			'{ncca_pkg::CmdLoad, 10'd0, 16'h0000, 16'h0000, 1, '0},
			'{ncca_pkg::CmdLoad, 10'd1, 16'h7fff, 16'h7fff, 1, '0},
			'{ncca_pkg::CmdLoad, 10'd64, 16'hffff, 16'hffff, 1, '0},
			'{ncca_pkg::CmdLoad, 10'd1023, 16'h8000, 16'h8000, 1, '0},
			'{ncca_pkg::CmdClassify, 10'd0, 16'h0000, 16'h0000, 1,
				'{33'd0, 1'b0, 1'b0, 4'd0}},
			'{ncca_pkg::CmdClassify, 10'd1023, 16'h7fff, 16'h7fff, 1,
				'{33'd0, 1'b0, 1'b0, 4'd1}},
			'{ncca_pkg::CmdClassify, 10'd5, 16'h8000, 16'h8000, 1,
				'{33'd2147483648, 1'b0, 1'b0, 4'd0}},
			'{ncca_pkg::CmdClassify, 10'd6, 16'h7fff, 16'h8000, 0, '0},
			'{ncca_pkg::CmdLoad, 10'd2, 16'h0000, 16'h0000, 1, '0},
			'{ncca_pkg::CmdLoad, 10'd3, 16'h0064, 16'hff9c, 1, '0},
			'{ncca_pkg::CmdSpare, 10'd0, 16'hffff, 16'hffff, 1, '0},
			'{ncca_pkg::CmdClear, 10'd1023, 16'hffff, 16'hffff, 1, '0},
			'{ncca_pkg::CmdClassify, 10'd7, 16'h3fff, 16'hc001, 0, '0}
		};
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		@(negedge clk);
		foreach (rows[i]) begin
			send(rows[i].cmd, rows[i].idx, rows[i].x, rows[i].y, rows[i].typed, rows[i].res);
			if (rows[i].cmd == ncca_pkg::CmdClassify && !pt_written[rows[i].idx]) begin
				pt_written[rows[i].idx] = 1;
				pt_list.push_back(rows[i].idx);
			end
		end
		drain();
		// Fill every core slot, with many small values so that ties occur.
		for (int s = 4; s < ncca_pkg::NumSlots; s++)
			send(ncca_pkg::CmdLoad, 10'(s),
				$urandom_range(0, 1) ? rand_coord() : 16'($urandom_range(0, 2)),
				$urandom_range(0, 1) ? rand_coord() : 16'($urandom_range(0, 2)), 0, '0);
		drain();
		write_reg(ncca_pkg::RegSpare, 5'h1f);
		for (int ph = 0; ph < 10; ph++) begin
			set_config(phase_k[ph], phase_p[ph], phase_i[ph]);
			if (ph == 1) begin
				hold_req = 1;
				repeat (6) send_random();
			end
			if (ph == 9)
				idle_on = 0;
			for (int n = 0; n < phase_n[ph]; n++)
				send_random();
		end
		drain();
		repeat (100) @(posedge clk);
		if (labels_due.size() != 0)
			report("results never arrived", '0, labels_due[0]);
		$display("Covered %0d results, %0d classifies, %0d label changes, %0d distance ties,",
			n_results, n_classify, n_changed, n_ties);
		$display("over ten register settings including saturated and initial-pass ones.");
		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

/* filelist.f */
hdl/ncca_pkg.sv
hdl/ncca_cell.sv
hdl/ncca_ram.sv
hdl/nearest_core_cluster_assign.sv
test/tb_top.sv
